FILE: rtl/core/brms_pkg.sv
// Package for the block RMS meter.
// Holds widths, reset values and register codes shared by all of its modules.
`default_nettype none

package brms_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_BLOCK_DEF   = 64;

    localparam int LEN_W   = 7;
    localparam int LEN_MAX = (1 << LEN_W) - 1;
    localparam logic [LEN_W-1:0] LENGTH_AT_RESET = 7'd10;

    localparam int FRAC_SHIFT = 8;
    localparam int RMS_W      = 20;
    localparam int SUM_W      = 38;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_BLOCK_LENGTH = 1'b0;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

endpackage

`default_nettype wire

FILE: rtl/core/brms_front.sv
// Front end of the block RMS meter: takes samples, squares and accumulates them.
// Pushes the finished block sum and its length into the queue. Uses brms_pkg.
`default_nettype none

module brms_front #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_BLOCK   = 64,
    parameter int ACC_W       = 39
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [SAMPLE_BITS-1:0]        sample,
    input  wire logic [brms_pkg::LEN_W-1:0]    block_length,
    input  wire logic                          q_full,
    output logic                               push,
    output logic [ACC_W-1:0]                   push_sum,
    output logic [brms_pkg::LEN_W-1:0]         push_len
);
    import brms_pkg::*;

    localparam int NMAX = (MAX_BLOCK < LEN_MAX) ? MAX_BLOCK : LEN_MAX;
    localparam int SQ_W = 2 * SAMPLE_BITS;

    logic                 sq_valid_reg, sq_valid_next;
    logic                 sq_last_reg, sq_last_next;
    logic [SQ_W-1:0]      sq_reg, sq_next;
    logic [LEN_W-1:0]     sq_len_reg, sq_len_next;
    logic [LEN_W-1:0]     count_reg, count_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [LEN_W-1:0]     n_eff;
    logic [LEN_W-1:0]     count_inc;
    logic [ACC_W-1:0]     acc_sum;
    logic                 accept;
    logic                 advance;
    logic                 is_last;

    always_comb
    begin
        if (block_length == '0)
        begin
            n_eff = LEN_W'(1);
        end
        else if (block_length > LEN_W'(NMAX))
        begin
            n_eff = LEN_W'(NMAX);
        end
        else
        begin
            n_eff = block_length;
        end
    end

    assign advance   = !sq_last_reg || !q_full;
    assign in_stall  = sq_valid_reg && !advance;
    assign accept    = in_valid && !in_stall;
    assign count_inc = count_reg + LEN_W'(1);
    assign is_last   = (count_inc >= n_eff);
    assign acc_sum   = acc_reg + ACC_W'(sq_reg);

    assign push     = sq_valid_reg && sq_last_reg && advance;
    assign push_sum = acc_sum;
    assign push_len = sq_len_reg;

    always_comb
    begin
        sq_valid_next = sq_valid_reg;
        sq_last_next  = sq_last_reg;
        sq_next       = sq_reg;
        sq_len_next   = sq_len_reg;
        count_next    = count_reg;
        acc_next      = acc_reg;

        if (sq_valid_reg && advance)
        begin
            acc_next      = sq_last_reg ? '0 : acc_sum;
            sq_valid_next = 1'b0;
        end

        if (accept)
        begin
            sq_valid_next = 1'b1;
            sq_next       = SQ_W'(sample) * SQ_W'(sample);
            sq_last_next  = is_last;
            sq_len_next   = n_eff;
            count_next    = is_last ? '0 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
            sq_last_reg  <= 1'b0;
            count_reg    <= '0;
            acc_reg      <= '0;
        end
        else
        begin
            sq_valid_reg <= sq_valid_next;
            sq_last_reg  <= sq_last_next;
            count_reg    <= count_next;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg     <= sq_next;
        sq_len_reg <= sq_len_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/brms_queue.sv
// Two-entry queue between the front and back ends of the block RMS meter.
// Holds one block sum and its length per entry. Uses brms_pkg.
`default_nettype none

module brms_queue #(
    parameter int ACC_W = 39
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire logic [ACC_W-1:0]              push_sum,
    input  wire logic [brms_pkg::LEN_W-1:0]    push_len,
    output logic                               full,
    input  wire logic                          pop,
    output logic                               not_empty,
    output logic [ACC_W-1:0]                   head_sum,
    output logic [brms_pkg::LEN_W-1:0]         head_len
);
    import brms_pkg::*;

    logic [ACC_W-1:0]  sum_mem [QUEUE_DEPTH];
    logic [LEN_W-1:0]  len_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;

    assign full      = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head_sum  = sum_mem[rd_ptr_reg];
    assign head_len  = len_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            sum_mem[wr_ptr_reg] <= push_sum;
            len_mem[wr_ptr_reg] <= push_len;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/brms_back.sv
// Back end of the block RMS meter: divides the scaled block sum by its length,
// takes the integer square root one bit per cycle and holds the result. Uses brms_pkg.
`default_nettype none

module brms_back #(
    parameter int ACC_W = 39
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_not_empty,
    input  wire logic [ACC_W-1:0]              q_sum,
    input  wire logic [brms_pkg::LEN_W-1:0]    q_len,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [brms_pkg::RMS_W-1:0]         rms_value,
    output logic [brms_pkg::SUM_W-1:0]         square_sum
);
    import brms_pkg::*;

    localparam int DW    = ACC_W + FRAC_SHIFT;
    localparam int RW    = (DW + 1) / 2;
    localparam int XW    = 2 * RW;
    localparam int CNT_W = $clog2(DW + 1);
    localparam int CW    = (RW > RMS_W) ? RW : RMS_W;
    localparam int SW    = (ACC_W > SUM_W) ? ACC_W : SUM_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  step_reg, step_next;
    logic [ACC_W-1:0]  sum_reg, sum_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [DW-1:0]     div_reg, div_next;
    logic [LEN_W-1:0]  drem_reg, drem_next;
    logic [XW-1:0]     x_reg, x_next;
    logic [RW+1:0]     srem_reg, srem_next;
    logic [RW-1:0]     root_reg, root_next;
    logic              out_valid_reg, out_valid_next;
    logic [RMS_W-1:0]  rms_reg, rms_next;
    logic [SUM_W-1:0]  osum_reg, osum_next;

    logic [LEN_W:0]    d_shift;
    logic              d_ge;
    logic [RW+1:0]     s_shift;
    logic [RW+1:0]     s_trial;
    logic              s_ge;
    logic [CW-1:0]     root_ext;
    logic [SW-1:0]     sum_ext;
    logic              out_free;

    assign d_shift  = {drem_reg, div_reg[DW-1]};
    assign d_ge     = (d_shift >= {1'b0, len_reg});
    assign s_shift  = {srem_reg[RW-1:0], x_reg[XW-1:XW-2]};
    assign s_trial  = {root_reg, 2'b01};
    assign s_ge     = (s_shift >= s_trial);
    assign root_ext = CW'(root_reg);
    assign sum_ext  = SW'(sum_reg);
    assign out_free = !out_valid_reg || !out_stall;

    assign q_pop      = (state_reg == ST_IDLE) && q_not_empty;
    assign out_valid  = out_valid_reg;
    assign rms_value  = rms_reg;
    assign square_sum = osum_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        sum_next       = sum_reg;
        len_next       = len_reg;
        div_next       = div_reg;
        drem_next      = drem_reg;
        x_next         = x_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        out_valid_next = out_valid_reg;
        rms_next       = rms_reg;
        osum_next      = osum_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    sum_next   = q_sum;
                    len_next   = q_len;
                    div_next   = {q_sum, {FRAC_SHIFT{1'b0}}};
                    drem_next  = '0;
                    step_next  = CNT_W'(DW);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                div_next  = {div_reg[DW-2:0], d_ge};
                drem_next = d_ge ? LEN_W'(d_shift - {1'b0, len_reg}) : d_shift[LEN_W-1:0];
                step_next = step_reg - CNT_W'(1);
                if (step_reg == CNT_W'(1))
                begin
                    x_next     = XW'({div_reg[DW-2:0], d_ge});
                    srem_next  = '0;
                    root_next  = '0;
                    step_next  = CNT_W'(RW);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                x_next    = {x_reg[XW-3:0], 2'b00};
                srem_next = s_ge ? s_shift - s_trial : s_shift;
                root_next = {root_reg[RW-2:0], s_ge};
                step_next = step_reg - CNT_W'(1);
                if (step_reg == CNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (root_ext > CW'((1 << RMS_W) - 1))
                    begin
                        rms_next = '1;
                    end
                    else
                    begin
                        rms_next = root_ext[RMS_W-1:0];
                    end
                    if (sum_ext > SW'({SUM_W{1'b1}}))
                    begin
                        osum_next = '1;
                    end
                    else
                    begin
                        osum_next = sum_ext[SUM_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            len_reg       <= '0;
            div_reg       <= '0;
            drem_reg      <= '0;
            x_reg         <= '0;
            srem_reg      <= '0;
            root_reg      <= '0;
            rms_reg       <= '0;
            osum_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            sum_reg       <= sum_next;
            len_reg       <= len_next;
            div_reg       <= div_next;
            drem_reg      <= drem_next;
            x_reg         <= x_next;
            srem_reg      <= srem_next;
            root_reg      <= root_next;
            rms_reg       <= rms_next;
            osum_reg      <= osum_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/block_rms_meter.sv
// Top level of the block RMS meter: configuration register and the
// front end, queue and back end. Uses brms_pkg, brms_front, brms_queue, brms_back.
//
// Usage: samples enter on the input channel (in_valid, in_stall, sample). Each
// sample is squared and added to the running block sum. After block_length
// samples one item leaves on the output channel (out_valid, out_stall,
// rms_value, square_sum) and the block sum restarts.
// The front end takes one sample per cycle while the input is not stalled. The back
// end restores the mean by a one-bit-per-cycle divider and an integer square root
// of one bit per cycle; it takes the next block from the queue only once it has
// handed on its current result. A two-entry queue holds blocks waiting for the back
// end; the input stalls only when that queue is full. block_length is written through
// the APB port at byte address 0; the user must do so only while the block is idle,
// and the block itself does not enforce this. Zero acts as one, values above
// MAX_BLOCK act as MAX_BLOCK.
// Reset clears the block sum and count and sets block_length to 10.
// While the receiver stalls, the result item holds; the back end finishes its next
// block and waits, and the front end keeps taking samples until the queue fills.
`default_nettype none

module block_rms_meter #(
    parameter int SAMPLE_BITS = brms_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_BLOCK   = brms_pkg::MAX_BLOCK_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [brms_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [brms_pkg::PDATA_W-1:0]    pwdata,
    output logic [brms_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [SAMPLE_BITS-1:0]          sample,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [brms_pkg::RMS_W-1:0]           rms_value,
    output logic [brms_pkg::SUM_W-1:0]           square_sum
);
    import brms_pkg::*;

    localparam int NMAX  = (MAX_BLOCK < LEN_MAX) ? MAX_BLOCK : LEN_MAX;
    localparam int ACC_W = 2 * SAMPLE_BITS + $clog2(NMAX + 1);

    logic [LEN_W-1:0] length_reg, length_next;
    logic             reg_sel;
    logic             push;
    logic [ACC_W-1:0] push_sum;
    logic [LEN_W-1:0] push_len;
    logic             q_full;
    logic             q_pop;
    logic             q_not_empty;
    logic [ACC_W-1:0] q_sum;
    logic [LEN_W-1:0] q_len;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1] == REG_BLOCK_LENGTH);
    assign prdata  = reg_sel ? PDATA_W'(length_reg) : '0;

    always_comb
    begin
        length_next = length_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            length_next = pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= LENGTH_AT_RESET;
        end
        else
        begin
            length_reg <= length_next;
        end
    end

    brms_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_BLOCK   (MAX_BLOCK),
        .ACC_W       (ACC_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .block_length (length_reg),
        .q_full       (q_full),
        .push         (push),
        .push_sum     (push_sum),
        .push_len     (push_len)
    );

    brms_queue #(
        .ACC_W (ACC_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_sum  (push_sum),
        .push_len  (push_len),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_sum  (q_sum),
        .head_len  (q_len)
    );

    brms_back #(
        .ACC_W (ACC_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_sum       (q_sum),
        .q_len       (q_len),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .rms_value   (rms_value),
        .square_sum  (square_sum)
    );

endmodule

`default_nettype wire

FILE: tb/block_rms_meter_tb.sv
// Self-checking testbench for block_rms_meter: drives samples and APB writes, predicts
// each block's sum of squares and Q.4 RMS, and checks every output item in order.
// Depends on brms_pkg and the block_rms_meter RTL.
`timescale 1ns / 100ps

module block_rms_meter_tb;

    import brms_pkg::*;

    localparam int UNMAPPED_REG = 1;
    localparam int SETTLE_CYCLES = 120;

    typedef struct packed {
        logic [RMS_W-1:0] rms;
        logic [SUM_W-1:0] sum;
    } block_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [PDATA_W-1:0]     pwdata = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [15:0]            sample = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [RMS_W-1:0]       rms_value;
    logic [SUM_W-1:0]       square_sum;

    logic [38:0]            square_acc;
    logic [LEN_W-1:0]       sample_cnt;
    logic [LEN_W-1:0]       length_reg;
    block_result_t          pending_blocks[$];

    int                     mismatches = 0;
    int                     idle_pct = 0;
    int                     stall_pct = 0;
    int                     hold_request = 0;
    int                     hold_left = 0;

    block_rms_meter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .rms_value  (rms_value),
        .square_sum (square_sum)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        rem = v;
        root = '0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic void accumulate_sample(input logic [15:0] s);
        logic [LEN_W-1:0] n;
        logic [63:0]      mean;
        logic [63:0]      root;
        block_result_t    res;
        n = length_reg;
        if (n == 0)
            n = LEN_W'(1);
        if (n > MAX_BLOCK_DEF)
            n = LEN_W'(MAX_BLOCK_DEF);
        square_acc = square_acc + 39'(s) * 39'(s);
        sample_cnt = sample_cnt + 1'b1;
        if (sample_cnt < n)
            return;
        mean = (64'(square_acc) << FRAC_SHIFT) / 64'(n);
        root = floor_sqrt(mean);
        res.rms = (root > 64'((1 << RMS_W) - 1)) ? '1 : root[RMS_W-1:0];
        res.sum = (square_acc > 39'((64'd1 << SUM_W) - 1)) ? '1 : square_acc[SUM_W-1:0];
        pending_blocks.push_back(res);
        square_acc = '0;
        sample_cnt = '0;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        block_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_blocks.size() == 0)
            begin
                report_mismatch("unexpected item", 64'(square_sum), 64'd0);
            end
            else
            begin
                want = pending_blocks.pop_front();
                if (rms_value !== want.rms)
                    report_mismatch("rms_value", 64'(rms_value), 64'(want.rms));
                if (square_sum !== want.sum)
                    report_mismatch("square_sum", 64'(square_sum), 64'(want.sum));
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_sample(input logic [15:0] s);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            sample <= 16'($urandom);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        accumulate_sample(s);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input int idx, input logic [PDATA_W-1:0] value);
        wait_idle();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * idx);
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_BLOCK_LENGTH)
            length_reg = value[LEN_W-1:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_block_length(input int len);
        apb_write(REG_BLOCK_LENGTH, ($urandom & ~32'h7F) | PDATA_W'(len));
    endtask

    function automatic logic [15:0] random_sample();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int random_length();
        case ($urandom_range(9))
            0: return 0;
            1: return $urandom_range(65, 127);
            2: return MAX_BLOCK_DEF;
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    task automatic test_reset_length();
        logic [15:0] samples[10] = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001,
                                    16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h00FF};
        foreach (samples[i])
            send_sample(samples[i]);
    endtask

    task automatic test_single_sample_blocks();
        set_block_length(1);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'hAAAA);
    endtask

    task automatic test_zero_length();
        set_block_length(0);
        send_sample(16'h5555);
        send_sample(16'hFFFF);
    endtask

    task automatic test_length_lowered();
        set_block_length(6);
        repeat (3) send_sample(random_sample());
        set_block_length(2);
        apb_write(UNMAPPED_REG, 32'd5);
        send_sample(random_sample());
        repeat (2) send_sample(random_sample());
    endtask

    task automatic test_length_extremes();
        set_block_length(LEN_MAX);
        repeat (MAX_BLOCK_DEF) send_sample(16'hFFFF);
        set_block_length(MAX_BLOCK_DEF);
        repeat (64) send_sample(random_sample());
        set_block_length(MAX_BLOCK_DEF + 1);
        repeat (40) send_sample(random_sample());
    endtask

    task automatic test_random(input int idle, input int stall);
        idle_pct = idle;
        stall_pct = stall;
        repeat (3)
        begin
            set_block_length(random_length());
            repeat (20) send_sample(random_sample());
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    task automatic test_backpressure();
        set_block_length(1);
        hold_request = 300;
        repeat (24) send_sample(random_sample());
        wait_idle();
    endtask

    initial
    begin
        square_acc = '0;
        sample_cnt = '0;
        length_reg = LENGTH_AT_RESET;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_length();
        test_single_sample_blocks();
        test_zero_length();
        test_length_lowered();
        test_length_extremes();
        test_random(0, 0);
        test_random(80, 0);
        test_random(0, 80);
        test_random(13, 13);
        test_backpressure();

        wait_idle();
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
